// ----- rtl/clcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Character LCD controller package
// Shared sizes, codes, payload types and the controller state type.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int ROWS   = 4;
  localparam int COLS   = 20;
  localparam int CELLS  = ROWS * COLS;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int ROW_W  = 2;
  localparam int COL_W  = 5;
  localparam int CHAR_W = 7;
  localparam int ADDR_W = 7;

  localparam logic [ROW_W:0]   ROWS_X   = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]   COLS_X   = (COL_W + 1)'(COLS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_STATUS = 2'd1;
  localparam logic [1:0] REQ_CELL   = 2'd2;

  localparam logic [7:0] CTRL_COMMAND = 8'h80;
  localparam logic [7:0] CTRL_CHAR    = 8'h40;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] FLAG_MASK    = 8'hF8;
  localparam logic [7:0] FLAG_CODE    = 8'h08;
  localparam logic [7:0] FIRST_PRINT  = 8'h20;
  localparam logic [7:0] LAST_PRINT   = 8'h7E;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       ctrl_code;
    logic [7:0]       data_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] status_byte;
    logic [CHAR_W-1:0] cell_char;
    logic [ROW_W-1:0]  cur_row_out;
    logic [COL_W-1:0]  cur_col_out;
    logic              display_flag;
    logic              cursor_flag;
    logic              blink_flag;
    logic              unknown_control;
  } out_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              clr;
  } st_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ----- rtl/character_lcd_controller.sv -----
// ----------------------------------------------------------------------------
// Character LCD controller
// 4 x 20 character display controller with bus writes, status and cell reads.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers at a rising edge with start high and busy low. It is
//   a bus write pair (command or character), a status read, or a cell read.
//   Every request gives one result on out_data, marked by out_strobe for a
//   single cycle; the execute state follows the transfer and the result is
//   registered at its end. The receiver cannot stall the block, so each
//   result must be captured in its strobe cycle. busy is high in the
//   execute state, which reads or writes the character store and updates
//   cursor state; the next request may transfer while the registered result
//   is presented. For clear, per-cell valid bits drop at once.
//   cfg_data (device enable) transfers when cfg_valid is high; cfg_ready is
//   always high. Write it only while no request is in flight.
//   Synchronous reset blanks all cells, homes the cursor, sets display on,
//   cursor and blink off, and enables the device.
// ----------------------------------------------------------------------------
module character_lcd_controller (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  clcd_pkg::in_t   in_data,
  output logic            out_strobe,
  output clcd_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data
);
  import clcd_pkg::*;

  st_cmd_t           st_cmd;
  logic [CHAR_W-1:0] rd_data;

  clcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .st_cmd     (st_cmd),
    .rd_data    (rd_data)
  );

  clcd_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (st_cmd),
    .rd_data (rd_data)
  );

endmodule

// ----- rtl/clcd_store.sv -----
// ----------------------------------------------------------------------------
// Character store
// Cell memory with registered read and one valid bit per cell; a cell whose
// valid bit is clear reads as a space, so reset and clear only drop valid bits.
// ----------------------------------------------------------------------------
module clcd_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clcd_pkg::st_cmd_t             cmd,
  output logic [clcd_pkg::CHAR_W-1:0]   rd_data
);
  import clcd_pkg::*;

  logic [CHAR_W-1:0] mem [CELLS];
  logic [CELLS-1:0]  vld_r;
  logic [CHAR_W-1:0] rd_mem_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_mem_r <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        vld_r <= '0;
      end else if (cmd.wr_en) begin
        vld_r[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[cmd.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_mem_r : SPACE_CHAR;

endmodule

// ----- rtl/clcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Controller sequencer
// Decodes requests, holds cursor, address and flags, drives the character
// store and registers one result per transfer.
// ----------------------------------------------------------------------------
module clcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  clcd_pkg::in_t       in_data,
  output logic                out_strobe,
  output clcd_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  output clcd_pkg::st_cmd_t   st_cmd,
  input  logic [clcd_pkg::CHAR_W-1:0] rd_data
);
  import clcd_pkg::*;

  state_t            state_r, state_nxt;
  logic              accept, exec_en;

  in_t               req_r;
  logic              in_range, in_range_r;
  logic              dev_en_r;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              disp_r, disp_nxt;
  logic              curs_r, curs_nxt;
  logic              blink_r, blink_nxt;

  logic              out_strobe_r;
  out_t              out_data_r, out_data_nxt;

  logic [ROW_W:0]    row_inc;
  logic [COL_W:0]    col_inc;
  logic [CHAR_W-1:0] ch;
  logic              wr_en, clr, unknown;
  logic [ADDR_W-1:0] status;
  logic [CHAR_W-1:0] cell_chr;
  logic [7:0]        d;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    accept  = 1'b0;
    exec_en = 1'b0;
    unique case (state_r)
      ST_IDLE: accept = start;
      ST_EXEC: begin
        busy    = 1'b1;
        exec_en = 1'b1;
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  assign in_range = ({1'b0, in_data.read_row} < ROWS_X) &&
                    ({1'b0, in_data.read_col} < COLS_X);

  assign d  = req_r.data_code;
  assign ch = (d >= FIRST_PRINT && d <= LAST_PRINT) ? d[CHAR_W-1:0] : SPACE_CHAR;
  assign row_inc = {1'b0, row_r} + (ROW_W + 1)'(1);
  assign col_inc = {1'b0, col_r} + (COL_W + 1)'(1);

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    addr_nxt  = addr_r;
    disp_nxt  = disp_r;
    curs_nxt  = curs_r;
    blink_nxt = blink_r;
    wr_en     = 1'b0;
    clr       = 1'b0;
    unknown   = 1'b0;
    status    = '0;
    cell_chr  = '0;
    if (exec_en) begin
      case (req_r.req_type)
        REQ_WRITE: begin
          if (dev_en_r) begin
            if (req_r.ctrl_code == CTRL_COMMAND) begin
              if (d == CMD_CLEAR) begin
                clr      = 1'b1;
                row_nxt  = '0;
                col_nxt  = '0;
                addr_nxt = '0;
              end else if (d == CMD_HOME) begin
                row_nxt  = '0;
                col_nxt  = '0;
                addr_nxt = '0;
              end else if (d[7]) begin
                addr_nxt = d[ADDR_W-1:0];
                row_nxt  = ({1'b0, d[6:5]} >= ROWS_X) ? LAST_ROW : d[6:5];
                col_nxt  = ({1'b0, d[4:0]} >= COLS_X) ? LAST_COL : d[4:0];
              end else if ((d & FLAG_MASK) == FLAG_CODE) begin
                disp_nxt  = d[2];
                curs_nxt  = d[1];
                blink_nxt = d[0];
              end
            end else if (req_r.ctrl_code == CTRL_CHAR) begin
              wr_en = 1'b1;
              if (col_inc >= COLS_X) begin
                col_nxt = '0;
                row_nxt = (row_inc >= ROWS_X) ? '0 : row_inc[ROW_W-1:0];
              end else begin
                col_nxt = col_inc[COL_W-1:0];
              end
              addr_nxt = {row_nxt, col_nxt};
            end else begin
              unknown = 1'b1;
            end
          end
        end
        REQ_STATUS: status = addr_r;
        REQ_CELL:   cell_chr = in_range_r ? rd_data : SPACE_CHAR;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_cmd.rd_en   = accept;
    st_cmd.rd_addr = in_range ?
                     IDX_W'(in_data.read_row) * IDX_W'(COLS) + IDX_W'(in_data.read_col) :
                     '0;
    st_cmd.wr_en   = wr_en;
    st_cmd.wr_addr = IDX_W'(row_r) * IDX_W'(COLS) + IDX_W'(col_r);
    st_cmd.wr_data = ch;
    st_cmd.clr     = clr;
  end

  always_comb begin
    out_data_nxt.status_byte     = status;
    out_data_nxt.cell_char       = cell_chr;
    out_data_nxt.cur_row_out     = row_nxt;
    out_data_nxt.cur_col_out     = col_nxt;
    out_data_nxt.display_flag    = disp_nxt;
    out_data_nxt.cursor_flag     = curs_nxt;
    out_data_nxt.blink_flag      = blink_nxt;
    out_data_nxt.unknown_control = unknown;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      dev_en_r     <= 1'b1;
      row_r        <= '0;
      col_r        <= '0;
      addr_r       <= '0;
      disp_r       <= 1'b1;
      curs_r       <= 1'b0;
      blink_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= exec_en;
      if (cfg_valid && cfg_ready) begin
        dev_en_r <= cfg_data;
      end
      if (exec_en) begin
        row_r   <= row_nxt;
        col_r   <= col_nxt;
        addr_r  <= addr_nxt;
        disp_r  <= disp_nxt;
        curs_r  <= curs_nxt;
        blink_r <= blink_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_data;
      in_range_r <= in_range;
    end
    if (exec_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ----- rtl/clcd_checker.sv -----
// ----------------------------------------------------------------------------
// Character LCD controller checker
// Port-level checks on request and result transfers and on cursor range.
// ----------------------------------------------------------------------------
module clcd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_strobe,
  input clcd_pkg::out_t  out_data
);
  import clcd_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result missing two cycles after request transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({1'b0, out_data.cur_col_out} < COLS_X &&
                    {1'b0, out_data.cur_row_out} < ROWS_X))
    else $error("cursor outside display");

endmodule

bind character_lcd_controller clcd_checker u_clcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
